>>> design/tssq_pkg.sv
// Shared types and constants for the timed setpoint schedule queue.
// No dependencies; every other design file refers to this package by scoped name.
package tssq_pkg;

  localparam int TIME_W  = 32;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Operation codes carried by each input item
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
  localparam logic [OP_W-1:0] OP_PREDICT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 2'd2;

  // Register reset values
  localparam logic [VALUE_W-1:0] LOWER_RESET   = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] UPPER_RESET   = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] INITIAL_RESET = 32'h0000_0000;
  localparam logic [TIME_W-1:0]  TIME_EMPTY    = 32'hFFFF_FFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;      // capture the accepted item
    logic ins_start;  // start the insert scan at the tail
    logic ins_read;   // read the entry just below the scan position
    logic ins_shift;  // move the read entry up one slot
    logic ins_place;  // write the new entry at the scan position
    logic adv_read;   // read the front entry
    logic adv_pop;    // apply the front setpoint and drop the front entry
    logic adv_mark;   // close the advance: record time, refresh front
    logic clear;      // empty the queue
    logic set_drop;   // flag a rejected insert
    logic pred_read;  // read the front entry for a due prediction
    logic out_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic count_zero;
    logic full;
    logic repeat_adv;  // advance to the same time as the previous one
    logic pred_due;    // front entry is due at the queried time
    logic k_zero;      // insert scan has reached the front
    logic rd_later;    // entry just read is later than the item time
  } status_t;

endpackage

>>> design/tssq_if.sv
// Handshake channels for input items and result items.
// Depends on tssq_pkg for field widths.
interface tssq_item_if;
  logic                           valid;
  logic                           ready;
  logic [tssq_pkg::OP_W-1:0]      op;
  logic [tssq_pkg::TIME_W-1:0]    event_time;
  logic signed [tssq_pkg::VALUE_W-1:0] target_value;

  modport source (output valid, op, event_time, target_value, input ready);
  modport sink   (input valid, op, event_time, target_value, output ready);
endinterface

interface tssq_result_if #(parameter int CNT_W = 5);
  logic                           valid;
  logic                           ready;
  logic signed [tssq_pkg::VALUE_W-1:0] result_value;
  logic [tssq_pkg::TIME_W-1:0]    next_due_time;
  logic [CNT_W-1:0]               entry_count;
  logic                           dropped;

  modport source (output valid, result_value, next_due_time, entry_count, dropped,
                  input ready);
  modport sink   (input valid, result_value, next_due_time, entry_count, dropped,
                  output ready);
endinterface

>>> design/tssq_ctrl.sv
// Sequencer for the schedule queue: decodes each item and steps the datapath.
// Depends on tssq_pkg for the command and status structs and the operation codes.
module tssq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tssq_pkg::status_t status,
  output tssq_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_INS_CHK = 3'd2;
  localparam logic [2:0] S_INS_CMP = 3'd3;
  localparam logic [2:0] S_ADV_CHK = 3'd4;
  localparam logic [2:0] S_ADV_CMP = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          tssq_pkg::OP_INSERT: begin
            if (status.full) begin
              cmd.set_drop = 1'b1;
              state_next   = S_FINISH;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_INS_CHK;
            end
          end
          tssq_pkg::OP_ADVANCE: begin
            state_next = status.repeat_adv ? S_FINISH : S_ADV_CHK;
          end
          tssq_pkg::OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_FINISH;
          end
          default: begin
            cmd.pred_read = status.pred_due;
            state_next    = S_FINISH;
          end
        endcase
      end
      S_INS_CHK: begin
        if (status.k_zero) begin
          cmd.ins_place = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.ins_read = 1'b1;
          state_next   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status.rd_later) begin
          cmd.ins_shift = 1'b1;
          state_next    = S_INS_CHK;
        end else begin
          cmd.ins_place = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_ADV_CHK: begin
        if (status.count_zero) begin
          cmd.adv_mark = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.adv_read = 1'b1;
          state_next   = S_ADV_CMP;
        end
      end
      S_ADV_CMP: begin
        if (!status.rd_later) begin
          cmd.adv_pop = 1'b1;
          state_next  = S_ADV_CHK;
        end else begin
          cmd.adv_mark = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the state; hold the result valid until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/tssq_dpath.sv
// Datapath of the schedule queue: circular entry memory, limits, setpoint and result register.
// Depends on tssq_pkg for widths, codes and the command and status structs.
module tssq_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tssq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tssq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [tssq_pkg::OP_W-1:0]             op,
  input  logic [tssq_pkg::TIME_W-1:0]           event_time,
  input  logic signed [tssq_pkg::VALUE_W-1:0]   target_value,
  input  tssq_pkg::cmd_t                        cmd,
  output tssq_pkg::status_t                     status,
  output logic signed [tssq_pkg::VALUE_W-1:0]   result_value,
  output logic [tssq_pkg::TIME_W-1:0]           next_due_time,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      entry_count,
  output logic                                  dropped
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_WIDE = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT  = CW'(QUEUE_DEPTH);

  // Entry storage, sorted by time, earliest first from head
  logic [tssq_pkg::TIME_W-1:0]  time_mem  [QUEUE_DEPTH];
  logic [tssq_pkg::VALUE_W-1:0] value_mem [QUEUE_DEPTH];

  logic [tssq_pkg::OP_W-1:0]           op_q;
  logic [tssq_pkg::TIME_W-1:0]         time_q;
  logic signed [tssq_pkg::VALUE_W-1:0] value_q;
  logic                                drop;
  logic                                pred_hit;

  logic signed [tssq_pkg::VALUE_W-1:0] lower_limit;
  logic signed [tssq_pkg::VALUE_W-1:0] upper_limit;
  logic signed [tssq_pkg::VALUE_W-1:0] current;
  logic [tssq_pkg::TIME_W-1:0]         front_time;
  logic [tssq_pkg::TIME_W-1:0]         last_time;
  logic                                advanced_once;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] k;

  logic                                rd_en;
  logic [AW-1:0]                       rd_addr;
  logic [tssq_pkg::TIME_W-1:0]         rd_time;
  logic signed [tssq_pkg::VALUE_W-1:0] rd_value;
  logic                                wr_en;
  logic [AW-1:0]                       wr_addr;
  logic [tssq_pkg::TIME_W-1:0]         wr_time;
  logic [tssq_pkg::VALUE_W-1:0]        wr_value;
  logic signed [tssq_pkg::VALUE_W-1:0] clamped;

  // Physical slot of a queue position: one compare and subtract
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_WIDE) begin
      sum = sum - DEPTH_WIDE;
    end
    return sum[AW-1:0];
  endfunction

  // Memory port addressing
  always_comb begin
    rd_en    = cmd.ins_read || cmd.adv_read || cmd.pred_read;
    rd_addr  = cmd.ins_read ? wrap_add(head, k - AW'(1)) : head;
    wr_en    = cmd.ins_shift || cmd.ins_place;
    wr_addr  = wrap_add(head, k);
    wr_time  = cmd.ins_shift ? rd_time : time_q;
    wr_value = cmd.ins_shift ? rd_value : value_q;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr]  <= wr_time;
      value_mem[wr_addr] <= wr_value;
    end
    if (rd_en) begin
      rd_time  <= time_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

  // Clamp the entry just read; the upper test wins
  always_comb begin
    if (rd_value > upper_limit) begin
      clamped = upper_limit;
    end else if (rd_value < lower_limit) begin
      clamped = lower_limit;
    end else begin
      clamped = rd_value;
    end
  end

  // Status back to the controller
  always_comb begin
    status.op         = op_q;
    status.count_zero = (count == '0);
    status.full       = (count == DEPTH_CNT);
    status.repeat_adv = advanced_once && (time_q == last_time);
    status.pred_due   = (count != '0) && (time_q >= front_time);
    status.k_zero     = (k == '0);
    status.rd_later   = (rd_time > time_q);
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= op;
      time_q  <= event_time;
      value_q <= target_value;
    end
  end

  // Queue control state, limits and setpoint
  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      count         <= '0;
      k             <= '0;
      front_time    <= tssq_pkg::TIME_EMPTY;
      last_time     <= '0;
      advanced_once <= 1'b0;
      drop          <= 1'b0;
      pred_hit      <= 1'b0;
      lower_limit   <= tssq_pkg::LOWER_RESET;
      upper_limit   <= tssq_pkg::UPPER_RESET;
      current       <= tssq_pkg::INITIAL_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tssq_pkg::CFG_LOWER_LIMIT:   lower_limit <= cfg_data;
          tssq_pkg::CFG_UPPER_LIMIT:   upper_limit <= cfg_data;
          tssq_pkg::CFG_INITIAL_VALUE: begin
            // only reaches the output until the first advance
            if (!advanced_once) begin
              current <= cfg_data;
            end
          end
          default: ;
        endcase
      end
      if (cmd.latch) begin
        drop     <= 1'b0;
        pred_hit <= 1'b0;
      end
      if (cmd.set_drop) begin
        drop <= 1'b1;
      end
      if (cmd.pred_read) begin
        pred_hit <= 1'b1;
      end
      // Sorted insert: scan down from the tail
      if (cmd.ins_start) begin
        k <= count[AW-1:0];
      end
      if (cmd.ins_shift) begin
        k <= k - AW'(1);
      end
      if (cmd.ins_place) begin
        count <= count + CW'(1);
        if (k == '0) begin
          front_time <= time_q;
        end
      end
      // Pop due entries from the front
      if (cmd.adv_pop) begin
        current <= clamped;
        head    <= wrap_add(head, AW'(1));
        count   <= count - CW'(1);
      end
      if (cmd.adv_mark) begin
        last_time     <= time_q;
        advanced_once <= 1'b1;
        front_time    <= (count == '0) ? tssq_pkg::TIME_EMPTY : rd_time;
      end
      if (cmd.clear) begin
        count      <= '0;
        front_time <= tssq_pkg::TIME_EMPTY;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value  <= pred_hit ? clamped : current;
      next_due_time <= front_time;
      entry_count   <= count;
      dropped       <= drop;
    end
  end

endmodule

>>> design/timed_setpoint_schedule_queue.sv
// Timed setpoint schedule queue: time-sorted (time, setpoint) entries with clamped output.
// Clear, predict, a repeated advance and a rejected insert go from decode to finish; an
// insert scans down from the tail, moving each later entry up a slot, then places the item; an
// advance pops each due entry from the front, then records the time. Each step is one read
// and one compare. A waiting result holds the block; the next item is taken after the load.
// Synchronous reset empties the queue and restores the register defaults; no memory clear.
module timed_setpoint_schedule_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tssq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tssq_pkg::CFG_DATA_W-1:0]   cfg_data,
  tssq_item_if.sink                         item_ch,
  tssq_result_if.source                     result_ch
);

  tssq_pkg::cmd_t    cmd;
  tssq_pkg::status_t status;

  // Sequencer
  tssq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_ch.valid),
    .item_ready (item_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Storage and arithmetic
  tssq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (item_ch.op),
    .event_time    (item_ch.event_time),
    .target_value  (item_ch.target_value),
    .cmd           (cmd),
    .status        (status),
    .result_value  (result_ch.result_value),
    .next_due_time (result_ch.next_due_time),
    .entry_count   (result_ch.entry_count),
    .dropped       (result_ch.dropped)
  );

endmodule
